// File: sv/cfar_pkg.sv
// Shared types, constants and the arctangent table of the CFAR peak detector.
package cfar_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int AGE_W        = $clog2(WINDOW_DEPTH);
    localparam int SAMPLE_BITS  = 16;
    localparam int MAG_W        = 17;
    localparam int SUM_W        = 24;
    localparam int CORDIC_ITERS = 24;
    localparam int CORDIC_W     = 34;
    localparam int SEARCH_MAX   = 32;

    // Register index, byte address 4*index
    typedef enum logic [2:0] {
        REG_LEAD_START = 3'd0,
        REG_LEAD_END   = 3'd1,
        REG_LAG_START  = 3'd2,
        REG_LAG_END    = 3'd3,
        REG_THRESHOLD  = 3'd4,
        REG_SEARCH     = 3'd5,
        REG_SKIP       = 3'd6,
        REG_UNUSED     = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] signal_re;
        logic signed [SAMPLE_BITS-1:0] signal_im;
        logic signed [SAMPLE_BITS-1:0] corr_re;
        logic signed [SAMPLE_BITS-1:0] corr_im;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_signal_re;
        logic signed [SAMPLE_BITS-1:0] out_signal_im;
        logic signed [SAMPLE_BITS-1:0] out_corr_re;
        logic signed [SAMPLE_BITS-1:0] out_corr_im;
        logic                          detected;
        logic [4:0]                    peak_offset;
        logic signed [15:0]            peak_phase;
    } result_t;

    // One delay-line entry: both samples plus the correlation magnitude
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sig_re;
        logic signed [SAMPLE_BITS-1:0] sig_im;
        logic signed [SAMPLE_BITS-1:0] corr_re;
        logic signed [SAMPLE_BITS-1:0] corr_im;
        logic [MAG_W-1:0]              mag;
    } line_entry_t;

    // atan(2^-i), 2^32 = 2pi
    function automatic logic [31:0] cfar_atan(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/ca_cfar_peak_detector.sv
// Top level of the cell-averaging CFAR peak detector: control, ring of cells, APB registers.
// Each item is squared and its magnitude loaded, then passes the bit-serial square root,
// whose result is handed over and pushed with the entry into the 64-cell delay line; the
// ring then rotates once past the single tap at its end (which accumulates the training
// sum, picks the cell under test and searches for the peak), followed by the threshold
// multiply and compare, the CORDIC phase on a detection, and the load of the output
// register. A new item is taken as soon as the previous one sits in the output register.
module ca_cfar_peak_detector
    import cfar_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sample_t     sample_data,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROOT, ST_SHIFT, ST_SCAN, ST_MUL, ST_CMP, ST_PHASE, ST_DONE
    } state_t;

    state_t             state_reg;
    logic signed [6:0]  lead_start_reg;
    logic signed [7:0]  lead_end_reg;
    logic signed [6:0]  lag_start_reg;
    logic signed [7:0]  lag_end_reg;
    logic [15:0]        threshold_reg;
    logic [5:0]         search_reg;
    logic [7:0]         skip_reg;
    logic [8:0]         holdoff_reg;
    logic               reload_reg;

    sample_t            sample_reg;
    logic [AGE_W-1:0]   step_reg;
    logic [SUM_W-1:0]   sum_reg;
    line_entry_t        cut_reg;
    logic [4:0]         best_reg;
    logic [MAG_W-1:0]   best_mag_reg;
    logic signed [15:0] peak_re_reg;
    logic signed [15:0] peak_im_reg;
    logic [33:0]        prod_l_reg;
    logic [39:0]        prod_r_reg;
    logic               det_reg;
    logic signed [15:0] phase_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    line_entry_t        line_q [WINDOW_DEPTH];
    line_entry_t        line_d [WINDOW_DEPTH];
    line_entry_t        new_entry;
    line_entry_t        tail;
    logic               advance;

    logic               accept;
    logic               cfg_write;
    logic               root_done;
    logic [MAG_W-1:0]   root_val;
    logic               cordic_start;
    logic               cordic_done;
    logic signed [15:0] cordic_phase;

    logic [5:0]         srch;
    logic signed [8:0]  top_off;
    logic signed [8:0]  bottom_off;
    logic [8:0]         span;
    logic signed [8:0]  offset;
    logic               in_lead;
    logic               in_lag;
    logic [SUM_W-1:0]   add_lead;
    logic [SUM_W-1:0]   add_lag;
    logic signed [8:0]  lead_len;
    logic signed [8:0]  lag_len;
    logic [8:0]         n_cells;
    logic [25:0]        cut_n;
    logic               det;
    logic [8:0]         hold_base;
    logic [8:0]         hold_new;

    assign accept    = sample_valid && !sample_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign sample_stall = (state_reg != ST_IDLE);
    assign pready    = 1'b1;

    // Window geometry from the registers
    always_comb
    begin
        srch = (search_reg > 6'(SEARCH_MAX)) ? 6'(SEARCH_MAX) : search_reg;
        top_off = $signed({3'b000, srch});
        if (9'(lead_end_reg) - 9'sd1 > top_off)
        begin
            top_off = 9'(lead_end_reg) - 9'sd1;
        end
        if (9'(lag_end_reg) - 9'sd1 > top_off)
        begin
            top_off = 9'(lag_end_reg) - 9'sd1;
        end
        bottom_off = 9'sd0;
        if (9'(lead_start_reg) < bottom_off)
        begin
            bottom_off = 9'(lead_start_reg);
        end
        if (9'(lag_start_reg) < bottom_off)
        begin
            bottom_off = 9'(lag_start_reg);
        end
        span     = 9'(top_off - bottom_off + 9'sd1);
        lead_len = 9'(lead_end_reg) - 9'(lead_start_reg);
        lag_len  = 9'(lag_end_reg) - 9'(lag_start_reg);
        n_cells  = ((lead_len > 0) ? 9'(lead_len) : 9'd0)
                 + ((lag_len > 0) ? 9'(lag_len) : 9'd0);
    end

    // Ring of cells: load the new entry at the head, or rotate the tail back around
    assign new_entry = '{sig_re: sample_reg.signal_re, sig_im: sample_reg.signal_im,
                         corr_re: sample_reg.corr_re, corr_im: sample_reg.corr_im,
                         mag: root_val};
    assign advance = (state_reg == ST_SHIFT) || (state_reg == ST_SCAN);
    assign tail    = line_q[WINDOW_DEPTH-1];

    always_comb
    begin
        line_d[0] = (state_reg == ST_SHIFT) ? new_entry : tail;
        for (int k = 1; k < WINDOW_DEPTH; k++)
        begin
            line_d[k] = line_q[k-1];
        end
    end

    for (genvar k = 0; k < WINDOW_DEPTH; k++)
    begin : g_line
        cfar_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .d       (line_d[k]),
            .q       (line_q[k])
        );
    end

    // The tail holds age WINDOW_DEPTH-1-step during the rotation
    assign offset   = top_off - $signed({3'b000, ~step_reg});
    assign in_lead  = (offset >= 9'(lead_start_reg)) && (offset < 9'(lead_end_reg));
    assign in_lag   = (offset >= 9'(lag_start_reg)) && (offset < 9'(lag_end_reg));
    assign add_lead = in_lead ? SUM_W'(tail.mag) : '0;
    assign add_lag  = in_lag ? SUM_W'(tail.mag) : '0;

    assign cut_n     = 26'(cut_reg.mag) * 26'(n_cells);
    assign det       = (holdoff_reg == 9'd0) && (40'(prod_l_reg) > prod_r_reg);
    assign hold_base = det ? (9'(best_reg) + 9'(skip_reg)) : holdoff_reg;
    assign hold_new  = (hold_base != 9'd0) ? hold_base - 9'd1 : 9'd0;
    assign cordic_start = (state_reg == ST_CMP) && det;

    cfar_root u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .re    (sample_data.corr_re),
        .im    (sample_data.corr_im),
        .done  (root_done),
        .root  (root_val)
    );

    cfar_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .re    (peak_re_reg),
        .im    (peak_im_reg),
        .done  (cordic_done),
        .phase (cordic_phase)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            lead_start_reg   <= -7'sd20;
            lead_end_reg     <= -8'sd4;
            lag_start_reg    <= 7'sd5;
            lag_end_reg      <= 8'sd21;
            threshold_reg    <= 16'd1974;
            search_reg       <= 6'd8;
            skip_reg         <= 8'd16;
            holdoff_reg      <= '0;
            reload_reg       <= 1'b1;
            step_reg         <= '0;
            det_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (reload_reg)
            begin
                holdoff_reg <= span;
            end
            // Unknown indices leave the hold-off alone
            reload_reg <= cfg_write && (paddr[4:2] != REG_UNUSED);
            if (cfg_write)
            begin
                unique case (paddr[4:2])
                    REG_LEAD_START: lead_start_reg <= pwdata[6:0];
                    REG_LEAD_END:   lead_end_reg   <= pwdata[7:0];
                    REG_LAG_START:  lag_start_reg  <= pwdata[6:0];
                    REG_LAG_END:    lag_end_reg    <= pwdata[7:0];
                    REG_THRESHOLD:  threshold_reg  <= pwdata[15:0];
                    REG_SEARCH:     search_reg     <= pwdata[5:0];
                    REG_SKIP:       skip_reg       <= pwdata[7:0];
                    default:        ;
                endcase
            end

            if (result_valid_reg && !result_stall && (state_reg != ST_DONE))
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        sample_reg <= sample_data;
                        state_reg  <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    if (root_done)
                    begin
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT:
                begin
                    step_reg     <= '0;
                    sum_reg      <= '0;
                    cut_reg      <= '0;
                    best_reg     <= '0;
                    best_mag_reg <= '0;
                    peak_re_reg  <= '0;
                    peak_im_reg  <= '0;
                    state_reg    <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    sum_reg <= sum_reg + add_lead + add_lag;
                    if (offset == 9'sd0)
                    begin
                        cut_reg      <= tail;
                        best_reg     <= '0;
                        best_mag_reg <= tail.mag;
                        peak_re_reg  <= tail.corr_re;
                        peak_im_reg  <= tail.corr_im;
                    end
                    else if ((offset > 9'sd0) && (offset < $signed({3'b000, srch}))
                             && (tail.mag > best_mag_reg))
                    begin
                        best_reg     <= offset[4:0];
                        best_mag_reg <= tail.mag;
                        peak_re_reg  <= tail.corr_re;
                        peak_im_reg  <= tail.corr_im;
                    end
                    step_reg <= step_reg + AGE_W'(1);
                    if (step_reg == AGE_W'(WINDOW_DEPTH - 1))
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_l_reg <= {cut_n, 8'b0};
                    prod_r_reg <= 40'(threshold_reg) * 40'(sum_reg);
                    state_reg  <= ST_CMP;
                end
                ST_CMP:
                begin
                    det_reg     <= det;
                    phase_reg   <= '0;
                    holdoff_reg <= hold_new;
                    state_reg   <= det ? ST_PHASE : ST_DONE;
                end
                ST_PHASE:
                begin
                    if (cordic_done)
                    begin
                        phase_reg <= cordic_phase;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    // Hold until the output register is free
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_reg.out_signal_re <= cut_reg.sig_re;
                        result_reg.out_signal_im <= cut_reg.sig_im;
                        result_reg.out_corr_re   <= cut_reg.corr_re;
                        result_reg.out_corr_im   <= cut_reg.corr_im;
                        result_reg.detected      <= det_reg;
                        result_reg.peak_offset   <= det_reg ? best_reg : 5'd0;
                        result_reg.peak_phase    <= det_reg ? phase_reg : 16'sd0;
                        result_valid_reg         <= 1'b1;
                        state_reg                <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_LEAD_START: prdata = {25'd0, lead_start_reg};
            REG_LEAD_END:   prdata = {24'd0, lead_end_reg};
            REG_LAG_START:  prdata = {25'd0, lag_start_reg};
            REG_LAG_END:    prdata = {24'd0, lag_end_reg};
            REG_THRESHOLD:  prdata = {16'd0, threshold_reg};
            REG_SEARCH:     prdata = {26'd0, search_reg};
            REG_SKIP:       prdata = {24'd0, skip_reg};
            default:        prdata = '0;
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule

// File: sv/cfar_cell.sv
// One delay-line cell: holds an entry and takes its neighbor's when the line moves.
module cfar_cell
    import cfar_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  line_entry_t d,
    output line_entry_t q
);

    line_entry_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (advance)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

// File: sv/cfar_root.sv
// Bit-serial magnitude unit: floor(sqrt(re^2 + im^2)), one result bit per cycle.
module cfar_root
    import cfar_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] re,
    input  logic signed [SAMPLE_BITS-1:0] im,
    output logic                          done,
    output logic [MAG_W-1:0]              root
);

    logic [31:0] re_sq_reg;
    logic [31:0] im_sq_reg;
    logic [31:0] rem_reg;
    logic [31:0] root_reg;
    logic [31:0] bit_reg;
    logic [3:0]  count_reg;
    logic        load_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] trial;

    assign trial = root_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg  <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            load_reg <= start;
            if (start)
            begin
                re_sq_reg <= 32'(re * re);
                im_sq_reg <= 32'(im * im);
            end
            if (load_reg)
            begin
                rem_reg   <= re_sq_reg + im_sq_reg;
                root_reg  <= '0;
                bit_reg   <= 32'h4000_0000;
                count_reg <= '0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg   <= bit_reg >> 2;
                count_reg <= count_reg + 4'd1;
                if (count_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg[MAG_W-1:0];

endmodule

// File: sv/cfar_cordic.sv
// Iterative vectoring CORDIC: negated phase of a complex sample, one iteration per cycle.
module cfar_cordic
    import cfar_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] re,
    input  logic signed [SAMPLE_BITS-1:0] im,
    output logic                          done,
    output logic signed [15:0]            phase
);

    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic [31:0]                ang_reg;
    logic                       zero_reg;
    logic [4:0]                 iter_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic signed [CORDIC_W-1:0] x_init;
    logic signed [CORDIC_W-1:0] y_init;
    logic signed [CORDIC_W-1:0] x_sh;
    logic signed [CORDIC_W-1:0] y_sh;
    logic [31:0]                rounded;

    assign x_init = CORDIC_W'(re) <<< 14;
    assign y_init = CORDIC_W'(im) <<< 14;
    assign x_sh   = x_reg >>> iter_reg;
    assign y_sh   = y_reg >>> iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                zero_reg <= (re == '0) && (im == '0);
                iter_reg <= '0;
                busy_reg <= 1'b1;
                // Left half plane: rotate by pi first
                if (re < 0)
                begin
                    x_reg   <= -x_init;
                    y_reg   <= -y_init;
                    ang_reg <= 32'h8000_0000;
                end
                else
                begin
                    x_reg   <= x_init;
                    y_reg   <= y_init;
                    ang_reg <= '0;
                end
            end
            else if (busy_reg)
            begin
                if (y_reg >= 0)
                begin
                    x_reg   <= x_reg + y_sh;
                    y_reg   <= y_reg - x_sh;
                    ang_reg <= ang_reg + cfar_atan(iter_reg);
                end
                else
                begin
                    x_reg   <= x_reg - y_sh;
                    y_reg   <= y_reg + x_sh;
                    ang_reg <= ang_reg - cfar_atan(iter_reg);
                end
                iter_reg <= iter_reg + 5'd1;
                if (iter_reg == 5'(CORDIC_ITERS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rounded = ang_reg + 32'h0000_8000;
    assign done    = done_reg;
    assign phase   = zero_reg ? 16'sd0 : $signed(16'(16'd0 - rounded[31:16]));

endmodule
